@@ sv/tpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and tables for the ternary packed int8 dot product.
// Used by the lane, merge, float unit and top-level modules.
package tpd_pkg;

  localparam int unsigned NumLanes  = 32;
  localparam int unsigned NumGroups = 4;
  localparam int unsigned GroupSize = NumLanes / NumGroups;
  localparam int unsigned ProdW     = 9;   // trit times int8
  localparam int unsigned GroupW    = 12;  // sum of eight products
  localparam int unsigned DotW      = 14;  // sum of 32 products
  localparam int unsigned InDataW   = 496;
  localparam int unsigned OutDataW  = 32;

  localparam logic [31:0] FpPosZero  = 32'h0000_0000;
  localparam logic [31:0] FpDefNan   = 32'hFFC0_0000;
  localparam logic [31:0] FpExpAll   = 32'h7F80_0000;
  localparam logic [31:0] FpQuietBit = 32'h0040_0000;

  typedef enum logic [0:0] {
    FP_MUL = 1'b0,
    FP_ADD = 1'b1
  } fp_op_t;

  typedef struct packed {
    fp_op_t      op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  // Powers of three used to pick a base-3 digit out of a packed byte.
  function automatic logic [7:0] pow3(input logic [2:0] k);
    logic [7:0] p;
    begin
      case (k)
        3'd0:    p = 8'd1;
        3'd1:    p = 8'd3;
        3'd2:    p = 8'd9;
        3'd3:    p = 8'd27;
        3'd4:    p = 8'd81;
        default: p = 8'd1;
      endcase
      return p;
    end
  endfunction

endpackage

@@ sv/tpd_lane.sv @@
`timescale 1ns / 1ps
// One lane: decodes a trit from a packed byte and applies it to one activation.
// Depends on tpd_pkg.
module tpd_lane
  import tpd_pkg::*;
(
  input  logic [7:0]                byte_i,
  input  logic [2:0]                k_i,
  input  logic signed [7:0]         act_i,
  output logic signed [ProdW-1:0]   prod_o
);

  logic [15:0] scaled;
  logic [9:0]  digit;

  always_comb begin
    scaled = 16'(byte_i) * 16'(pow3(k_i));
    digit  = (10'(scaled[7:0]) * 10'd3) >> 8;
    case (digit[1:0])
      2'd0:    prod_o = -ProdW'(act_i);
      2'd2:    prod_o = ProdW'(act_i);
      default: prod_o = '0;
    endcase
  end

endmodule

@@ sv/tpd_merge.sv @@
`timescale 1ns / 1ps
// Two-stage registered adder tree merging the 32 lane products into one dot.
// Depends on tpd_pkg.
module tpd_merge
  import tpd_pkg::*;
(
  input  logic                      clk,
  input  logic signed [ProdW-1:0]   prod_i [NumLanes],
  output logic signed [DotW-1:0]    dot_o
);

  logic signed [GroupW-1:0] grp_nxt [NumGroups];
  logic signed [GroupW-1:0] grp_r   [NumGroups];
  logic signed [DotW-1:0]   dot_nxt;
  logic signed [DotW-1:0]   dot_r;

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        grp_nxt[g] = grp_nxt[g] + GroupW'(prod_i[g*GroupSize + j]);
      end
    end
    dot_nxt = '0;
    for (int g = 0; g < NumGroups; g++) begin
      dot_nxt = dot_nxt + DotW'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    dot_r <= dot_nxt;
  end

  assign dot_o = dot_r;

endmodule

@@ sv/tpd_fpu.sv @@
`timescale 1ns / 1ps
// Single-precision multiply or add with round-to-nearest-even and subnormals.
// Depends on tpd_pkg for the request struct and NaN constants.
module tpd_fpu
  import tpd_pkg::*;
(
  input  fpu_req_t    req_i,
  output logic [31:0] y_o
);

  // Rounds m * 2^e to single precision.
  function automatic logic [31:0] rnd_pack(input logic s, input logic signed [10:0] e,
                                           input logic [47:0] m);
    logic [5:0]         lz;
    logic               found;
    logic [47:0]        n;
    logic [47:0]        sh_n;
    logic signed [11:0] be;
    logic signed [11:0] shv;
    logic [5:0]         sh;
    logic [23:0]        m24;
    logic               g;
    logic               st;
    logic [31:0]        pk;
    begin
      lz = '0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
        if (!found && m[i]) begin
          lz = 6'(47 - i);
          found = 1'b1;
        end
      end
      n  = m << lz;
      be = $signed({e[10], e}) + 12'sd174 - $signed({6'd0, lz});
      if (m == '0) begin
        return {s, 31'd0};
      end
      if (be >= 12'sd255) begin
        return {s, FpExpAll[30:0]};
      end
      if (be >= 12'sd1) begin
        m24 = n[47:24];
        g   = n[23];
        st  = |n[22:0];
        pk  = {1'b0, be[7:0] - 8'd1, 23'd0} + {8'd0, m24};
      end else begin
        shv  = 12'sd1 - be;
        sh   = (shv > 12'sd48) ? 6'd48 : shv[5:0];
        sh_n = n >> sh;
        m24  = sh_n[47:24];
        g    = sh_n[23];
        st   = (|sh_n[22:0]) | (|(n & ~({48{1'b1}} << sh)));
        pk   = {8'd0, m24};
      end
      pk = pk + {31'd0, g & (st | m24[0])};
      return {s, pk[30:0]};
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == '0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == '0;
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic signed [10:0] e;
    begin
      s  = a[31] ^ b[31];
      ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != '0, a[22:0]};
      mb = {b[30:23] != '0, b[22:0]};
      e  = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd300;
      if (is_nan(a)) begin
        return a | FpQuietBit;
      end else if (is_nan(b)) begin
        return b | FpQuietBit;
      end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
        return FpDefNan;
      end else if (is_inf(a) || is_inf(b)) begin
        return {s, FpExpAll[30:0]};
      end
      return rnd_pack(s, e, 48'(ma) * 48'(mb));
    end
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        big;
    logic [31:0]        sml;
    logic [7:0]         eb;
    logic [7:0]         es;
    logic [7:0]         d;
    logic [26:0]        x;
    logic [26:0]        y0;
    logic [26:0]        y;
    logic               st;
    logic [27:0]        sum;
    logic signed [10:0] e;
    begin
      if (is_nan(a)) begin
        return a | FpQuietBit;
      end else if (is_nan(b)) begin
        return b | FpQuietBit;
      end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
        return FpDefNan;
      end else if (is_inf(a)) begin
        return a;
      end else if (is_inf(b)) begin
        return b;
      end
      if (a[30:0] >= b[30:0]) begin
        big = a;
        sml = b;
      end else begin
        big = b;
        sml = a;
      end
      eb = (big[30:23] == '0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
      d  = eb - es;
      x  = {big[30:23] != '0, big[22:0], 3'd0};
      y0 = {sml[30:23] != '0, sml[22:0], 3'd0};
      if (d >= 8'd27) begin
        y  = '0;
        st = |y0;
      end else begin
        y  = y0 >> d;
        st = |(y0 & ~({27{1'b1}} << d));
      end
      y[0] = y[0] | st;
      if (big[31] == sml[31]) begin
        sum = 28'(x) + 28'(y);
      end else begin
        sum = 28'(x) - 28'(y);
      end
      if (sum == '0) begin
        return {a[31] & b[31], 31'd0};
      end
      e = $signed({3'd0, eb}) - 11'sd153;
      return rnd_pack(big[31], e, 48'(sum));
    end
  endfunction

  always_comb begin
    unique case (req_i.op)
      FP_MUL:  y_o = fmul(req_i.a, req_i.b);
      FP_ADD:  y_o = fadd(req_i.a, req_i.b);
      default: y_o = fmul(req_i.a, req_i.b);
    endcase
  end

endmodule

@@ sv/ternary_packed_int8_dot_product.sv @@
`timescale 1ns / 1ps
// Top level of the ternary packed int8 dot product: 32 trit lanes, merge tree
// and a sequencer around one shared single-precision float unit; uses tpd_pkg.
// A beat that ends a row shows its sum in the output register after the row accumulate.
// The sequencer walks each beat through the shared float unit and takes no new beat
// until it is done; sub-block 3 beats also take the weight multiply and row accumulate.
// Reset (rst_n low, synchronous) returns to sub-block 0 with a +0.0 row sum.
module ternary_packed_int8_dot_product
  import tpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // in_tdata, low bit up: weight_bytes_lo(64), weight_bytes_mid(64),
  // weight_bytes_hi(64), weight_tail(16), weight_scale(16), act_word0(64),
  // act_word1(64), act_word2(64), act_word3(64), act_scale(16)
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tlast,   // last_of_row
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_tdata, low bit up: row_sum(32)
  output logic [OutDataW-1:0] out_tdata
);

  // One-hot sequencer. A beat goes through load, the two tree stages, the
  // activation-scale multiply and the partial add; the fourth sub-block of a
  // block also takes the weight-scale multiply and the row accumulate.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LD   = 7'b0000010,
    S_RED  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_MULW = 7'b0100000,
    S_ACC  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]   sub_r, sub_nxt;        // next sub-block position in the block
  logic [1:0]   cur_sub_r;             // sub-block of the beat in flight
  logic [191:0] wb_r;
  logic [15:0]  tail_r;
  logic [15:0]  wscale_r;
  logic [255:0] act_r;
  logic [15:0]  ascale_r;
  logic         last_r;

  logic [31:0]  prod_r, prod_nxt;
  logic [31:0]  partial_r, partial_nxt;
  logic [31:0]  scaled_r, scaled_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_data_r, out_data_nxt;

  logic         in_fire;
  fpu_req_t     fpu_req;
  logic [31:0]  fpu_y;

  logic [7:0]             lane_byte [NumLanes];
  logic [2:0]             lane_k    [NumLanes];
  logic signed [ProdW-1:0] lane_prod [NumLanes];
  logic signed [DotW-1:0]  dot;

  // Exact widening of a half-precision value; subnormals are normalized.
  function automatic logic [31:0] h2f(input logic [15:0] h);
    logic [7:0] ex;
    logic [9:0] man;
    logic       found;
    begin
      ex = 8'(h[14:10]);
      man = h[9:0];
      if (h[14:10] == 5'd0) begin
        if (man == '0) begin
          return {h[15], 31'd0};
        end
        found = 1'b0;
        for (int p = 9; p >= 0; p--) begin
          if (!found && man[p]) begin
            ex  = 8'(103 + p);
            man = 10'(h[9:0] << (10 - p));
            found = 1'b1;
          end
        end
        return {h[15], ex, man, 13'd0};
      end else if (h[14:10] == 5'h1F) begin
        return {h[15], 8'hFF, man, 13'd0};
      end
      return {h[15], ex + 8'd112, man, 13'd0};
    end
  endfunction

  // Exact conversion of the integer dot, which never exceeds 4096 in magnitude.
  function automatic logic [31:0] i2f(input logic signed [DotW-1:0] v);
    logic [DotW-1:0] mag;
    logic [3:0]      msb;
    logic [22:0]     frac;
    begin
      mag = v[DotW-1] ? DotW'(-v) : DotW'(v);
      if (mag == '0) begin
        return FpPosZero;
      end
      msb = '0;
      for (int p = 0; p < DotW; p++) begin
        if (mag[p]) begin
          msb = 4'(p);
        end
      end
      frac = 23'({9'd0, mag} << (5'd23 - 5'(msb)));
      return {v[DotW-1], 8'd127 + 8'(msb), frac};
    end
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Trit map: which packed byte and which base-3 digit feed each element.
  always_comb begin
    for (int e = 0; e < NumLanes; e++) begin
      lane_byte[e] = '0;
      lane_k[e]    = '0;
      case (cur_sub_r)
        2'd0: begin
          if (e < 16) begin
            lane_byte[e] = wb_r[8*e +: 8];
            lane_k[e]    = 3'd0;
          end else begin
            lane_byte[e] = wb_r[8*(e-16) +: 8];
            lane_k[e]    = 3'd1;
          end
        end
        2'd1: begin
          if (e < 16) begin
            lane_byte[e] = wb_r[8*e +: 8];
            lane_k[e]    = 3'd2;
          end else begin
            lane_byte[e] = wb_r[8*(e-16) +: 8];
            lane_k[e]    = 3'd3;
          end
        end
        2'd2: begin
          if (e < 16) begin
            lane_byte[e] = wb_r[8*e +: 8];
            lane_k[e]    = 3'd4;
          end else if (e < 24) begin
            lane_byte[e] = wb_r[8*e +: 8];
            lane_k[e]    = 3'd0;
          end else begin
            lane_byte[e] = wb_r[8*(e-8) +: 8];
            lane_k[e]    = 3'd1;
          end
        end
        default: begin
          if (e < 8) begin
            lane_byte[e] = wb_r[8*(e+16) +: 8];
            lane_k[e]    = 3'd2;
          end else if (e < 16) begin
            lane_byte[e] = wb_r[8*(e+8) +: 8];
            lane_k[e]    = 3'd3;
          end else if (e < 24) begin
            lane_byte[e] = wb_r[8*e +: 8];
            lane_k[e]    = 3'd4;
          end else begin
            // Tail bytes alternate, one digit from each per step of k.
            lane_byte[e] = tail_r[8*((e-24)%2) +: 8];
            lane_k[e]    = 3'((e-24)/2);
          end
        end
      endcase
    end
  end

  for (genvar e = 0; e < NumLanes; e++) begin : g_lane
    tpd_lane u_lane (
      .byte_i (lane_byte[e]),
      .k_i    (lane_k[e]),
      .act_i  ($signed(act_r[8*e +: 8])),
      .prod_o (lane_prod[e])
    );
  end

  tpd_merge u_merge (
    .clk    (clk),
    .prod_i (lane_prod),
    .dot_o  (dot)
  );

  tpd_fpu u_fpu (
    .req_i (fpu_req),
    .y_o   (fpu_y)
  );

  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r;
    prod_nxt      = prod_r;
    partial_nxt   = partial_r;
    scaled_nxt    = scaled_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    fpu_req.op    = FP_MUL;
    fpu_req.a     = h2f(ascale_r);
    fpu_req.b     = i2f(dot);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_LD;
          sub_nxt   = sub_r + 2'd1;
        end
      end
      S_LD: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = fpu_y;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        fpu_req.op = FP_ADD;
        fpu_req.a  = partial_r;
        fpu_req.b  = prod_r;
        // The first sub-block of a block takes the product as it is.
        partial_nxt = (cur_sub_r == 2'd0) ? prod_r : fpu_y;
        state_nxt   = (cur_sub_r == 2'd3) ? S_MULW : S_IDLE;
      end
      S_MULW: begin
        fpu_req.op = FP_MUL;
        fpu_req.a  = partial_r;
        fpu_req.b  = h2f(wscale_r);
        scaled_nxt = fpu_y;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        fpu_req.op = FP_ADD;
        fpu_req.a  = acc_r;
        fpu_req.b  = scaled_r;
        if (!last_r) begin
          acc_nxt   = fpu_y;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          // Row end: hand the sum to the output register and restart at +0.0.
          out_valid_nxt = 1'b1;
          out_data_nxt  = fpu_y;
          acc_nxt       = FpPosZero;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= '0;
      acc_r       <= FpPosZero;
      partial_r   <= FpPosZero;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      acc_r       <= acc_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_sub_r <= sub_r;
      wb_r      <= in_tdata[191:0];
      tail_r    <= in_tdata[207:192];
      wscale_r  <= in_tdata[223:208];
      act_r     <= in_tdata[479:224];
      ascale_r  <= in_tdata[495:480];
      last_r    <= in_tlast;
    end
    prod_r     <= prod_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_beat_reaches_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##3 (state_r == S_MUL))
    else $error("accepted beat did not reach the scale multiply in time");

  a_short_block_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && cur_sub_r != 2'd3) |=> (state_r == S_IDLE))
    else $error("sub-block before the fourth did not return to idle");

  a_result_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_ACC && $past(last_r)))
    else $error("row sum raised outside a row-end accumulate");

endmodule
